/* sv/lbr_pkg.sv */
// Shared types, codes and colour helpers for the LED bar level renderer.
// No dependencies; used by every module of the block but lbr_fifo.
`timescale 1ns / 1ps
`default_nettype none

package lbr_pkg;

  // display modes
  localparam logic [1:0] MODE_BAR     = 2'd0;
  localparam logic [1:0] MODE_RAINBOW = 2'd1;
  localparam logic [1:0] MODE_SHINE   = 2'd2;
  localparam logic [1:0] MODE_OFF     = 2'd3;

  // request kinds
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam int unsigned FULL_BRIGHT = 255;
  localparam int unsigned SHINE_STEP  = FULL_BRIGHT / 9;

  // defaults for the top level parameters
  localparam int unsigned STRIP_LENGTH_DEF = 8;
  localparam int unsigned NUM_STRIPS_DEF   = 8;
  localparam int unsigned QUEUE_DEPTH      = 2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // fixed part of a render job; the lit count rides beside it
  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] strip;
    rgb_t       colour;
  } job_t;

  // one step around the colour wheel, three checks in order
  function automatic rgb_t rainbow_step(input rgb_t c);
    rgb_t n;
    n = c;
    if (n.red == 8'(FULL_BRIGHT)) begin
      if (n.blue != 8'd0) n.blue = n.blue - 8'd1;
      else n.green = n.green + 8'd1;
    end
    if (n.green == 8'(FULL_BRIGHT)) begin
      if (n.red != 8'd0) n.red = n.red - 8'd1;
      else n.blue = n.blue + 8'd1;
    end
    if (n.blue == 8'(FULL_BRIGHT)) begin
      if (n.green != 8'd0) n.green = n.green - 8'd1;
      else n.red = n.red + 8'd1;
    end
    return n;
  endfunction

  // brightness of the k-th top LED in shine mode
  function automatic logic [7:0] shine_top(input logic [1:0] k);
    logic [7:0] v;
    case (k)
      2'd1:    v = 8'(SHINE_STEP * 1);
      2'd2:    v = 8'(SHINE_STEP * 4);
      2'd3:    v = 8'(SHINE_STEP * 9);
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* sv/lbr_fifo.sv */
// Short register queue carrying render jobs from front to back end.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps
`default_nettype none

module lbr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    if (pop_i)  rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    if (push_i && !pop_i) cnt_d = cnt_q + CW'(1);
    else if (pop_i && !push_i) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i)) else $error("queue written while full");
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue read while empty");
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH)) else $error("queue fill count out of range");

endmodule

`default_nettype wire

/* sv/lbr_front.sv */
// Front end: takes requests, keeps mode, rainbow colour and the per-strip
// lit-count cache, and queues render jobs. Depends on lbr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbr_front #(
  parameter int unsigned STRIP_LENGTH = lbr_pkg::STRIP_LENGTH_DEF,
  parameter int unsigned NUM_STRIPS   = lbr_pkg::NUM_STRIPS_DEF,
  localparam int unsigned CW = $clog2(STRIP_LENGTH + 1)
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        opcode_i,
  input  wire logic [2:0]  strip_index_i,
  input  wire logic [7:0]  sample_i,
  output logic             push_o,
  output lbr_pkg::job_t    job_o,
  output logic [CW-1:0]    count_o,
  input  wire logic        full_i
);

  localparam int unsigned SW    = (NUM_STRIPS > 1) ? $clog2(NUM_STRIPS) : 1;
  localparam int unsigned DIV   = lbr_pkg::FULL_BRIGHT / STRIP_LENGTH;
  // ceil(2^16 / DIV): exact quotient for every 8-bit sample
  localparam int unsigned RECIP = (65536 + DIV - 1) / DIV;

  logic          vld_q;
  logic          op_q;
  logic [2:0]    strip_q;
  logic [7:0]    sample_q;
  logic [1:0]    mode_q;
  lbr_pkg::rgb_t rgb_q, rgb_d;
  logic [CW-1:0] lvl_q [NUM_STRIPS];

  logic [24:0]   prod;
  logic [7:0]    quo;
  logic [CW-1:0] cnt;
  logic [SW-1:0] sidx;
  logic          in_range;
  logic          refresh;
  logic          need_push;
  logic          done;

  // lit count: reciprocal multiply, then saturate
  assign prod = 25'(sample_q) * 25'(RECIP);
  assign quo  = prod[23:16];
  assign cnt  = (quo > 8'(STRIP_LENGTH)) ? CW'(STRIP_LENGTH) : CW'(quo);

  assign sidx     = SW'({{SW{1'b0}}, strip_q});
  assign in_range = ({2'b00, strip_q} < 5'(NUM_STRIPS));
  assign refresh  = (op_q == lbr_pkg::OP_SAMPLE) && in_range
                    && ((cnt != lvl_q[sidx]) || (mode_q == lbr_pkg::MODE_RAINBOW));
  assign need_push = refresh && (mode_q != lbr_pkg::MODE_OFF);
  assign done      = vld_q && (!need_push || !full_i);
  assign in_ready_o = !vld_q || done;

  assign push_o        = vld_q && need_push && !full_i;
  assign job_o.mode    = mode_q;
  assign job_o.strip   = strip_q;
  assign job_o.colour  = rgb_q;
  assign count_o       = cnt;

  // rainbow colour: config write to rainbow or a tick in rainbow mode
  always_comb begin
    rgb_d = rgb_q;
    if (cfg_we_i) begin
      if (cfg_wdata_i == lbr_pkg::MODE_RAINBOW) rgb_d.green = 8'(lbr_pkg::FULL_BRIGHT);
    end else if (done && (op_q == lbr_pkg::OP_TICK)
                 && (mode_q == lbr_pkg::MODE_RAINBOW)) begin
      rgb_d = lbr_pkg::rainbow_step(rgb_q);
    end
  end

  // control state and cache
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      mode_q <= lbr_pkg::MODE_RAINBOW;
      rgb_q  <= '{red: 8'd0, green: 8'(lbr_pkg::FULL_BRIGHT), blue: 8'd0};
      for (int n = 0; n < int'(NUM_STRIPS); n++) lvl_q[n] <= '0;
    end else begin
      rgb_q <= rgb_d;
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      if (in_valid_i && in_ready_o) vld_q <= 1'b1;
      else if (done) vld_q <= 1'b0;
      if (done && refresh) lvl_q[sidx] <= cnt;
    end
  end

  // request payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q     <= opcode_i;
      strip_q  <= strip_index_i;
      sample_q <= sample_i;
    end
  end

endmodule

`default_nettype wire

/* sv/lbr_back.sv */
// Back end: walks the LEDs of a queued job, one colour a cycle while the output
// is not stalled, into the output register. Depends on lbr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbr_back #(
  parameter int unsigned STRIP_LENGTH = lbr_pkg::STRIP_LENGTH_DEF,
  localparam int unsigned CW = $clog2(STRIP_LENGTH + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_valid_i,
  input  wire lbr_pkg::job_t job_i,
  input  wire logic [CW-1:0] count_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [2:0]         strip_out_o,
  output logic [2:0]         led_index_o,
  output lbr_pkg::rgb_t      colour_o,
  output logic               last_led_o
);

  localparam int unsigned IW = $clog2(STRIP_LENGTH);

  logic [IW-1:0] led_q, led_d;
  logic          out_vld_q;
  logic [2:0]    strip_q, ledx_q;
  lbr_pkg::rgb_t colour_q;
  logic          last_q;

  logic          load;
  logic          last;
  logic [CW:0]   li;
  logic [CW:0]   cx;
  logic [7:0]    shine;
  lbr_pkg::rgb_t colour;

  assign load  = job_valid_i && (!out_vld_q || out_ready_i);
  assign last  = (led_q == IW'(STRIP_LENGTH - 1));
  assign pop_o = load && last;
  assign led_d = last ? '0 : led_q + IW'(1);

  assign li = (CW + 1)'(led_q);
  assign cx = (CW + 1)'(count_i);

  // shine: only the top three lit LEDs, fading up
  always_comb begin
    if ((li + (CW + 1)'(3)) < cx) shine = 8'd0;
    else if (cx > (CW + 1)'(2)) shine = lbr_pkg::shine_top(2'(li + (CW + 1)'(4) - cx));
    else if (led_q == '0) shine = 8'(lbr_pkg::SHINE_STEP * 4);
    else shine = 8'(lbr_pkg::SHINE_STEP * 8);
  end

  // colour of the current LED
  always_comb begin
    colour = '0;
    if (li < cx) begin
      case (job_i.mode)
        lbr_pkg::MODE_BAR: begin
          if ((li + (CW + 1)'(3)) < (CW + 1)'(STRIP_LENGTH)) begin
            colour.green = 8'(lbr_pkg::FULL_BRIGHT);
          end else if ((li + (CW + 1)'(1)) < (CW + 1)'(STRIP_LENGTH)) begin
            colour.red   = 8'(lbr_pkg::FULL_BRIGHT);
            colour.green = 8'(lbr_pkg::FULL_BRIGHT);
          end else begin
            colour.red   = 8'(lbr_pkg::FULL_BRIGHT);
          end
        end
        lbr_pkg::MODE_RAINBOW: colour = job_i.colour;
        lbr_pkg::MODE_SHINE:   colour = '{red: shine, green: shine, blue: shine};
        default:               colour = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (load) led_q <= led_d;
      if (load) out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      strip_q  <= job_i.strip;
      ledx_q   <= 3'(led_q);
      colour_q <= colour;
      last_q   <= last;
    end
  end

  assign out_valid_o = out_vld_q;
  assign strip_out_o = strip_q;
  assign led_index_o = ledx_q;
  assign colour_o    = colour_q;
  assign last_led_o  = last_q;

  a_pop_on_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (led_q == IW'(STRIP_LENGTH - 1))) else $error("job released early");
  a_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (led_q == '0)) else $error("LED counter did not wrap");
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i) |=> $stable(led_q)) else $error("LED counter moved in stall");

endmodule

`default_nettype wire

/* sv/led_bar_level_colour_renderer_core.sv */
// Top level of the LED bar level renderer: front end, job queue, back end.
// Depends on lbr_pkg, lbr_front, lbr_fifo and lbr_back.
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+---------------------------------
//  s_axis   | in        | s_axis_tvalid/s_axis_tready | tuser opcode, tdata strip,sample
//  m_axis   | out       | m_axis_tvalid/m_axis_tready | tdata strip,led,r,g,b; tlast
//  cfg      | in        | cfg_we_i                    | cfg_wdata_i display mode
//
// A tick or an ignored sample leaves the front end without waiting on the queue.
// A rendered sample yields STRIP_LENGTH results, one a cycle unless m_axis_tready
// stalls, paced by the back end LED counter, via the queue and the output register.
// Reset: mode rainbow, rainbow colour green, every cached count zero.
// The queue lets requests enter while the back end or the consumer stalls.
`timescale 1ns / 1ps
`default_nettype none

module led_bar_level_colour_renderer_core #(
  parameter int unsigned STRIP_LENGTH = lbr_pkg::STRIP_LENGTH_DEF,
  parameter int unsigned NUM_STRIPS   = lbr_pkg::NUM_STRIPS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [2:0] strip_index, [10:3] sample, rest zero
  input  wire logic        s_axis_tuser,   // [0] opcode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [2:0] strip_out, [5:3] led_index,
                                           // [13:6] red, [21:14] green, [29:22] blue
  output logic             m_axis_tlast
);

  localparam int unsigned CW = $clog2(STRIP_LENGTH + 1);
  localparam int unsigned QW = $bits(lbr_pkg::job_t) + CW;

  logic          push, full, pop, empty;
  lbr_pkg::job_t job_w, job_r;
  logic [CW-1:0] cnt_w, cnt_r;
  logic [2:0]    strip_out, led_index;
  lbr_pkg::rgb_t colour;

  lbr_front #(
    .STRIP_LENGTH (STRIP_LENGTH),
    .NUM_STRIPS   (NUM_STRIPS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .opcode_i      (s_axis_tuser),
    .strip_index_i (s_axis_tdata[2:0]),
    .sample_i      (s_axis_tdata[10:3]),
    .push_o        (push),
    .job_o         (job_w),
    .count_o       (cnt_w),
    .full_i        (full)
  );

  lbr_fifo #(
    .WIDTH (QW),
    .DEPTH (lbr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({cnt_w, job_w}),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o ({cnt_r, job_r}),
    .empty_o (empty)
  );

  lbr_back #(
    .STRIP_LENGTH (STRIP_LENGTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!empty),
    .job_i       (job_r),
    .count_i     (cnt_r),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .strip_out_o (strip_out),
    .led_index_o (led_index),
    .colour_o    (colour),
    .last_led_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, colour.blue, colour.green, colour.red, led_index, strip_out};

endmodule

`default_nettype wire

/* tb/led_bar_level_colour_renderer_core_tb.sv */
// Self-checking bench for the LED bar level renderer core: stream requests in,
// one colour per LED out, checked against a behavioural copy of the block.
// Depends on lbr_pkg and led_bar_level_colour_renderer_core.
`timescale 1ns / 1ps

module led_bar_level_colour_renderer_core_tb;

  localparam int unsigned STRIP_LENGTH  = 8;
  localparam int unsigned NUM_STRIPS    = 8;
  localparam int unsigned LEVEL_STEP    = lbr_pkg::FULL_BRIGHT / STRIP_LENGTH;
  localparam int unsigned SETTLE_CYCLES = 16;

  typedef struct {
    logic       op;
    logic [2:0] strip;
    logic [7:0] sample;
  } req_t;

  typedef struct {
    logic [2:0]    strip;
    logic [2:0]    led;
    lbr_pkg::rgb_t colour;
    logic          last;
  } led_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_wdata_i = lbr_pkg::MODE_RAINBOW;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [2:0] strip_index, [10:3] sample, rest zero
  logic        s_axis_tuser = lbr_pkg::OP_TICK;  // [0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [2:0] strip_out, [5:3] led_index,
                                    // [13:6] red, [21:14] green, [29:22] blue
  logic        m_axis_tlast;

  // behavioural copy of the block state
  logic [1:0]    mode_m = lbr_pkg::MODE_RAINBOW;
  lbr_pkg::rgb_t wheel = '{red: 8'd0, green: 8'd255, blue: 8'd0};
  int unsigned   cached_count [NUM_STRIPS];

  req_t        req_q [$];
  led_res_t    led_q [$];
  req_t        cur_req;
  req_t        nxt_req;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  bit          sender_idle = 1'b0;
  int unsigned stall_style = 0;
  int unsigned stall_left = 0;
  int unsigned rdy_phase = 0;
  int unsigned bad_count = 0;

  led_bar_level_colour_renderer_core #(
    .STRIP_LENGTH(STRIP_LENGTH),
    .NUM_STRIPS  (NUM_STRIPS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // one step round the colour wheel; each check sees the previous ones
  function automatic void turn_wheel();
    if (wheel.red == 8'd255) begin
      if (wheel.blue != 8'd0) wheel.blue--;
      else wheel.green++;
    end
    if (wheel.green == 8'd255) begin
      if (wheel.red != 8'd0) wheel.red--;
      else wheel.blue++;
    end
    if (wheel.blue == 8'd255) begin
      if (wheel.green != 8'd0) wheel.green--;
      else wheel.red++;
    end
  endfunction

  // works out the LED colours a request causes and queues them
  function automatic void render_request(req_t r);
    int unsigned lit;
    int unsigned k;
    int unsigned v;
    int unsigned i;
    led_res_t    e;
    if (r.op == lbr_pkg::OP_TICK) begin
      if (mode_m == lbr_pkg::MODE_RAINBOW) turn_wheel();
      return;
    end
    if (r.strip >= NUM_STRIPS) return;
    lit = r.sample / LEVEL_STEP;
    if (lit > STRIP_LENGTH) lit = STRIP_LENGTH;
    if (lit == cached_count[r.strip] && mode_m != lbr_pkg::MODE_RAINBOW) return;
    cached_count[r.strip] = lit;
    if (mode_m == lbr_pkg::MODE_OFF) return;
    k = 0;
    for (i = 0; i < STRIP_LENGTH; i++) begin
      e.strip  = r.strip;
      e.led    = i[2:0];
      e.colour = '0;
      e.last   = (i == STRIP_LENGTH - 1);
      if (i < lit) begin
        case (mode_m)
          lbr_pkg::MODE_BAR: begin
            if (i + 3 < STRIP_LENGTH) e.colour.green = 8'd255;
            else if (i + 1 < STRIP_LENGTH) e.colour = '{8'd255, 8'd255, 8'd0};
            else e.colour.red = 8'd255;
          end
          lbr_pkg::MODE_SHINE: begin
            // only the top three lit LEDs glow, brightest at the top
            if (i + 3 < lit) v = 0;
            else if (lit > 2) begin
              k++;
              v = lbr_pkg::SHINE_STEP * k * k;
            end else v = lbr_pkg::SHINE_STEP * 4 * (i + 1);
            e.colour = '{v[7:0], v[7:0], v[7:0]};
          end
          default: e.colour = wheel;
        endcase
      end
      led_q.push_back(e);
    end
  endfunction

  // request driver: bursts of random length, random gaps between them if sender_idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      burst_left    <= 1;
      gap_left      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) render_request(cur_req);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left      <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (req_q.size() != 0) begin
          nxt_req = req_q.pop_front();
          cur_req       <= nxt_req;
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= nxt_req.op;
          s_axis_tdata  <= {5'b0, nxt_req.sample, nxt_req.strip};
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= sender_idle ? $urandom_range(1, 6) : 0;
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result back-pressure, style chosen per phase
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
      rdy_phase     <= 0;
    end else begin
      rdy_phase <= rdy_phase + 1;
      case (stall_style)
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        2: m_axis_tready <= ((rdy_phase % 11) < 7);
        3: begin
          if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
          end else if ($urandom_range(0, 15) == 0) begin
            stall_left    <= $urandom_range(5, 20);
            m_axis_tready <= 1'b0;
          end else begin
            m_axis_tready <= 1'b1;
          end
        end
        default: m_axis_tready <= 1'b1;
      endcase
    end
  end

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      bad_count++;
    end
  endtask

  // result monitor: compare with the oldest expected colour
  always @(posedge clk_i) begin
    led_res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (led_q.size() == 0) begin
        $error("unexpected result: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
        bad_count++;
      end else begin
        e = led_q.pop_front();
        check_field("strip_out", 8'(e.strip), 8'(m_axis_tdata[2:0]));
        check_field("led_index", 8'(e.led), 8'(m_axis_tdata[5:3]));
        check_field("red", e.colour.red, m_axis_tdata[13:6]);
        check_field("green", e.colour.green, m_axis_tdata[21:14]);
        check_field("blue", e.colour.blue, m_axis_tdata[29:22]);
        check_field("last_led", 8'(e.last), 8'(m_axis_tlast));
      end
    end
  end

  task automatic add_tick();
    req_t r;
    r = '{op: lbr_pkg::OP_TICK, strip: 3'($urandom_range(0, 7)),
          sample: 8'($urandom_range(0, 255))};
    req_q.push_back(r);
  endtask

  task automatic add_sample(int unsigned strip, int unsigned sample);
    req_t r;
    r = '{op: lbr_pkg::OP_SAMPLE, strip: 3'(strip), sample: 8'(sample)};
    req_q.push_back(r);
  endtask

  // samples lean towards the edges of the level bands
  function automatic int unsigned pick_sample();
    int unsigned edges [9] = '{0, 30, 31, 61, 62, 247, 248, 254, 255};
    if ($urandom_range(0, 3) == 0) return edges[$urandom_range(0, 8)];
    return $urandom_range(0, 255);
  endfunction

  task automatic add_random(int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 99) < 15) add_tick();
      else add_sample($urandom_range(0, 7), pick_sample());
    end
  endtask

  // wait for the sender to empty and every expected colour to arrive
  task automatic drain();
    do @(posedge clk_i);
    while (req_q.size() != 0 || s_axis_tvalid || led_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(logic [1:0] m);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mode_m = m;
    if (m == lbr_pkg::MODE_RAINBOW) wheel.green = 8'd255;
  endtask

  task automatic set_idling(int unsigned p);
    sender_idle = (p % 3 != 0);
    stall_style = p % 4;
  endtask

  initial begin
    logic [1:0] plan [8];
    int unsigned p;
    plan = '{lbr_pkg::MODE_SHINE, lbr_pkg::MODE_BAR, lbr_pkg::MODE_OFF,
             lbr_pkg::MODE_RAINBOW, lbr_pkg::MODE_RAINBOW, lbr_pkg::MODE_BAR,
             lbr_pkg::MODE_SHINE, lbr_pkg::MODE_RAINBOW};
    foreach (cached_count[j]) cached_count[j] = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // rainbow after reset: band edges, empty and full strips, repeats
    set_idling(1);
    add_sample(0, 0);
    add_tick();
    add_sample(7, 255);
    add_sample(1, 30);
    add_sample(1, 31);
    add_sample(2, 247);
    add_sample(3, 248);
    add_sample(4, 62);
    add_sample(7, 255);

    // bar colours; unchanged level and ticks give nothing
    write_mode(lbr_pkg::MODE_BAR);
    add_sample(7, 255);
    add_sample(7, 0);
    add_sample(0, 200);
    add_sample(5, 100);
    add_tick();
    add_sample(6, 255);

    // shine with one, two, three and many lit LEDs
    write_mode(lbr_pkg::MODE_SHINE);
    add_sample(0, 31);
    add_sample(0, 62);
    add_sample(0, 93);
    add_sample(0, 255);
    add_sample(0, 150);

    // display off still moves the cached level
    write_mode(lbr_pkg::MODE_OFF);
    add_sample(0, 0);
    add_tick();
    write_mode(lbr_pkg::MODE_BAR);
    add_sample(0, 0);

    // random phases over every mode
    for (p = 0; p < 8; p++) begin
      write_mode(plan[p]);
      set_idling(p);
      if (p == 3) begin
        // tick runs between samples move the wheel along step by step
        repeat (4) begin
          add_sample($urandom_range(0, 7), pick_sample());
          repeat (22) add_tick();
        end
      end else begin
        add_random(20);
      end
    end

    drain();
    if (bad_count == 0 && led_q.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
sv/lbr_pkg.sv
sv/lbr_fifo.sv
sv/lbr_front.sv
sv/lbr_back.sv
sv/led_bar_level_colour_renderer_core.sv
tb/led_bar_level_colour_renderer_core_tb.sv
